FILE: rtl/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared widths, defaults and medal codes for the score rank assigner.
// ----------------------------------------------------------------------------
package sra_pkg;

    // Default configuration of the top level.
    localparam int DEF_SCORE_BITS = 10;
    localparam int DEF_MAX_ITEMS  = 64;

    // Fixed widths of the result fields.
    localparam int ENTRANT_W = 6;
    localparam int RANK_W    = 7;
    localparam int MEDAL_W   = 2;

    // Medal codes.
    localparam logic [MEDAL_W-1:0] MEDAL_NONE   = 2'd0;
    localparam logic [MEDAL_W-1:0] MEDAL_GOLD   = 2'd1;
    localparam logic [MEDAL_W-1:0] MEDAL_SILVER = 2'd2;
    localparam logic [MEDAL_W-1:0] MEDAL_BRONZE = 2'd3;

    // Ranks one to three earn a medal; everything else earns none.
    function automatic logic [MEDAL_W-1:0] medal_of(input logic [RANK_W-1:0] rank);
        logic [MEDAL_W-1:0] code;
        case (rank)
            RANK_W'(1): code = MEDAL_GOLD;
            RANK_W'(2): code = MEDAL_SILVER;
            RANK_W'(3): code = MEDAL_BRONZE;
            default:    code = MEDAL_NONE;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/sra_ram.sv
// ----------------------------------------------------------------------------
// sra_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while the read enable is low.
// ----------------------------------------------------------------------------
module sra_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/score_rank_assigner_unit.sv
// ----------------------------------------------------------------------------
// score_rank_assigner_unit
// Counting-sort rank assignment: loads a batch of scores into a bucket memory,
// walks the buckets from the top score down to assign ranks, then emits one
// result per entrant in arrival order with its rank and medal code.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_score, i_last
//   result   out        o_valid / i_stall  o_entrant, o_rank, o_medal,
//                                          o_final_res
//
// Scores are taken one per cycle while the batch loads.
// After the last score the bucket walk reads from the top score down, one bucket
// memory read per cycle; results then leave at one per cycle while i_stall is low.
// After reset a clearing pass over all 2**SCORE_BITS entries empties the bucket
// memory; the input is stalled during that pass, the walk and the emission.
// A stalled result holds in the rank memory's read register.
// ----------------------------------------------------------------------------
module score_rank_assigner_unit #(
    parameter int SCORE_BITS = sra_pkg::DEF_SCORE_BITS,
    parameter int MAX_ITEMS  = sra_pkg::DEF_MAX_ITEMS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [SCORE_BITS-1:0]        i_score,
    input  logic                         i_last,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sra_pkg::ENTRANT_W-1:0] o_entrant,
    output logic [sra_pkg::RANK_W-1:0]    o_rank,
    output logic [sra_pkg::MEDAL_W-1:0]   o_medal,
    output logic                         o_final_res
);

    import sra_pkg::*;

    localparam int IDX_BITS   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int DEPTH      = 1 << SCORE_BITS;
    localparam int BUCKET_W   = IDX_BITS + 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // Control and batch state.
    logic [1:0]            r_state, n_state;
    logic [SCORE_BITS-1:0] r_addr, n_addr;
    logic [SCORE_BITS-1:0] r_top, n_top;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  r_issue, n_issue;
    logic                  r_chk, n_chk;
    logic [SCORE_BITS-1:0] r_chk_addr, n_chk_addr;
    logic [RANK_W-1:0]     r_next_rank, n_next_rank;
    logic [MAX_ITEMS-1:0]  r_rvalid, n_rvalid;
    logic [CNT_BITS-1:0]   r_k, n_k;
    logic                  r_out_valid, n_out_valid;
    logic [IDX_BITS-1:0]   r_out_k, n_out_k;
    logic                  r_out_rv, n_out_rv;
    logic                  r_out_last, n_out_last;

    // Memory ports.
    logic                  bkt_we;
    logic [SCORE_BITS-1:0] bkt_waddr;
    logic [BUCKET_W-1:0]   bkt_wdata;
    logic                  bkt_re;
    logic [BUCKET_W-1:0]   bkt_rdata;
    logic                  rnk_we;
    logic [IDX_BITS-1:0]   rnk_waddr;
    logic                  rnk_re;
    logic [RANK_W-1:0]     rnk_rdata;

    logic                  in_acc;
    logic                  out_acc;
    logic                  has_room;
    logic                  emit_issue;
    logic [CNT_BITS-1:0]   k_inc;
    logic                  bkt_hit;
    logic [IDX_BITS-1:0]   bkt_who;
    logic [RANK_W-1:0]     out_rank;

    // Bucket memory: one entry per score, a filled flag and the entrant slot.
    sra_ram #(
        .WIDTH  (BUCKET_W),
        .DEPTH  (DEPTH),
        .ADDR_W (SCORE_BITS)
    ) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (bkt_we),
        .i_waddr (bkt_waddr),
        .i_wdata (bkt_wdata),
        .i_re    (bkt_re),
        .i_raddr (r_addr),
        .o_rdata (bkt_rdata)
    );

    // Rank memory: one rank per entrant slot, qualified by r_rvalid.
    sra_ram #(
        .WIDTH  (RANK_W),
        .DEPTH  (MAX_ITEMS),
        .ADDR_W (IDX_BITS)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (rnk_we),
        .i_waddr (rnk_waddr),
        .i_wdata (r_next_rank),
        .i_re    (rnk_re),
        .i_raddr (r_k[IDX_BITS-1:0]),
        .o_rdata (rnk_rdata)
    );

    // Handshake decode.
    assign o_stall    = (r_state != ST_LOAD);
    assign in_acc     = i_valid && !o_stall;
    assign out_acc    = r_out_valid && !i_stall;
    assign has_room   = (r_count < CNT_BITS'(MAX_ITEMS));
    assign emit_issue = (r_state == ST_EMIT) && (r_k < r_count)
                        && (!r_out_valid || out_acc);
    assign k_inc      = r_k + CNT_BITS'(1);
    assign bkt_hit    = r_chk && bkt_rdata[IDX_BITS];
    assign bkt_who    = bkt_rdata[IDX_BITS-1:0];

    // Bucket write port: clearing pass, filing a score, or clearing on the walk.
    always_comb begin
        bkt_we    = 1'b0;
        bkt_waddr = r_addr;
        bkt_wdata = '0;
        case (r_state)
            ST_CLEAR: begin
                bkt_we = 1'b1;
            end
            ST_LOAD: begin
                bkt_we    = in_acc && has_room;
                bkt_waddr = i_score;
                bkt_wdata = {1'b1, r_count[IDX_BITS-1:0]};
            end
            ST_WALK: begin
                bkt_we    = r_chk;
                bkt_waddr = r_chk_addr;
            end
            default: begin
                bkt_we = 1'b0;
            end
        endcase
    end

    assign bkt_re    = (r_state == ST_WALK) && r_issue;
    assign rnk_we    = (r_state == ST_WALK) && bkt_hit;
    assign rnk_waddr = bkt_who;
    assign rnk_re    = emit_issue;

    // Next-state logic for the batch sequencer.
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_top       = r_top;
        n_count     = r_count;
        n_issue     = r_issue;
        n_chk       = 1'b0;
        n_chk_addr  = r_chk_addr;
        n_next_rank = r_next_rank;
        n_rvalid    = r_rvalid;
        n_k         = r_k;
        n_out_valid = r_out_valid;
        n_out_k     = r_out_k;
        n_out_rv    = r_out_rv;
        n_out_last  = r_out_last;
        case (r_state)
            ST_CLEAR: begin
                n_addr = r_addr + SCORE_BITS'(1);
                if (&r_addr) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (in_acc) begin
                    if (has_room) begin
                        n_count = r_count + CNT_BITS'(1);
                        if (i_score > r_top) begin
                            n_top = i_score;
                        end
                    end
                    if (i_last) begin
                        n_state     = ST_WALK;
                        n_issue     = 1'b1;
                        n_next_rank = RANK_W'(1);
                        n_addr      = (has_room && (i_score > r_top)) ? i_score : r_top;
                    end
                end
            end
            ST_WALK: begin
                // Issue one bucket read per cycle from the top score down.
                if (r_issue) begin
                    n_chk      = 1'b1;
                    n_chk_addr = r_addr;
                    if (r_addr == '0) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr - SCORE_BITS'(1);
                    end
                end
                // A filled bucket gives its entrant the next rank.
                if (bkt_hit) begin
                    n_next_rank       = r_next_rank + RANK_W'(1);
                    n_rvalid[bkt_who] = 1'b1;
                end
                if (!r_issue && r_chk) begin
                    n_state     = ST_EMIT;
                    n_k         = '0;
                    n_out_valid = 1'b0;
                end
            end
            ST_EMIT: begin
                if (emit_issue) begin
                    n_out_valid = 1'b1;
                    n_out_k     = r_k[IDX_BITS-1:0];
                    n_out_rv    = r_rvalid[r_k[IDX_BITS-1:0]];
                    n_out_last  = (k_inc == r_count);
                    n_k         = k_inc;
                end else if (out_acc) begin
                    n_out_valid = 1'b0;
                end
                // The final transaction of the batch returns to loading.
                if (out_acc && r_out_last) begin
                    n_state  = ST_LOAD;
                    n_count  = '0;
                    n_top    = '0;
                    n_rvalid = '0;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_top       <= '0;
            r_count     <= '0;
            r_issue     <= 1'b0;
            r_chk       <= 1'b0;
            r_next_rank <= RANK_W'(1);
            r_rvalid    <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_top       <= n_top;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_chk       <= n_chk;
            r_next_rank <= n_next_rank;
            r_rvalid    <= n_rvalid;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_chk_addr <= n_chk_addr;
        r_out_k    <= n_out_k;
        r_out_rv   <= n_out_rv;
        r_out_last <= n_out_last;
    end

    // Result fields; an entrant without a rank reports zero.
    assign out_rank    = r_out_rv ? rnk_rdata : '0;
    assign o_valid     = r_out_valid;
    assign o_entrant   = ENTRANT_W'(r_out_k);
    assign o_rank      = out_rank;
    assign o_medal     = medal_of(out_rank);
    assign o_final_res = r_out_last;

    // Results appear only while the batch is being emitted.
    a_out_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == ST_EMIT))
        else $error("result valid outside emission");

    // Ranks handed out never exceed the number of stored entrants.
    a_rank_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rnk_we |-> ({1'b0, r_next_rank} <= ((RANK_W+1)'(r_count))))
        else $error("rank beyond entrant count");

    // Taking the final result empties the batch state.
    a_batch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_out_last) |=> (r_state == ST_LOAD && r_count == '0
                                     && r_rvalid == '0))
        else $error("batch state not cleared after final result");

    // Every emitted entrant slot belongs to the stored batch.
    a_entrant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (CNT_BITS'(r_out_k) < r_count))
        else $error("emitted entrant outside the batch");

endmodule
